// ----- rtl/ddo_pkg.sv -----
// Shared types, constants and tables for the differential-drive odometry unit.
`timescale 1ns / 1ps
`default_nettype none

package ddo_pkg;

   // Default structure parameters
   localparam int CORDIC_ITERATIONS_DEFAULT = 24;
   localparam int POS_FRAC_BITS_DEFAULT     = 32;

   // Field widths
   localparam int STEP_W     = 16;
   localparam int POS_W      = 48;
   localparam int ANGLE_W    = 32;
   localparam int DPS_W      = 24;
   localparam int APS_W      = 26;

   // Configuration port
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISTANCE_PER_STEP = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_PER_STEP    = CSR_INDEX_W'(1);
   localparam logic [DPS_W-1:0] DPS_RESET = DPS_W'(553215);
   localparam logic [APS_W-1:0] APS_RESET = APS_W'(1693208);

   // Datapath widths
   localparam int SUM_W      = STEP_W + 1;            // step sum and difference
   localparam int TRAVEL_W   = 41;                    // |sum * dps| <= 2^40
   localparam int CORDIC_W   = 34;                    // x, y rotator registers
   localparam int ZW         = 32;                    // residual angle
   localparam int ATAN_IDX_W = 5;
   localparam int MAG_W      = 31;                    // |sin|, |cos| <= 2^30
   localparam int SPLIT_W    = 21;                    // low slice of travel magnitude
   localparam int PROD_W     = 72;                    // travel * trig product
   localparam int DELTA_W    = 50;                    // signed position step

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);
   localparam logic signed [CORDIC_W-1:0] Q30_ONE     = CORDIC_W'(1073741824);
   localparam logic signed [CORDIC_W-1:0] Q30_NEG     = -Q30_ONE;

   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   // Arctangent of 2^-i, binary angle with 2^32 per turn
   function automatic logic [ZW-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic [ZW-1:0] val;
      case (idx)
         5'd0:  val = 32'd536870912;
         5'd1:  val = 32'd316933406;
         5'd2:  val = 32'd167458907;
         5'd3:  val = 32'd85004756;
         5'd4:  val = 32'd42667331;
         5'd5:  val = 32'd21354465;
         5'd6:  val = 32'd10679838;
         5'd7:  val = 32'd5340245;
         5'd8:  val = 32'd2670163;
         5'd9:  val = 32'd1335087;
         5'd10: val = 32'd667544;
         5'd11: val = 32'd333772;
         5'd12: val = 32'd166886;
         5'd13: val = 32'd83443;
         5'd14: val = 32'd41722;
         5'd15: val = 32'd20861;
         5'd16: val = 32'd10430;
         5'd17: val = 32'd5215;
         5'd18: val = 32'd2608;
         5'd19: val = 32'd1304;
         5'd20: val = 32'd652;
         5'd21: val = 32'd326;
         5'd22: val = 32'd163;
         5'd23: val = 32'd81;
         5'd24: val = 32'd41;
         5'd25: val = 32'd20;
         5'd26: val = 32'd10;
         5'd27: val = 32'd5;
         5'd28: val = 32'd3;
         5'd29: val = 32'd1;
         5'd30: val = 32'd1;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

   typedef struct packed {
      logic signed [STEP_W-1:0] left_steps;
      logic signed [STEP_W-1:0] right_steps;
   } ddo_req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x_position;
      logic signed [POS_W-1:0] z_position;
      logic [ANGLE_W-1:0]      heading_angle;
   } ddo_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_ROTATE,
      ST_FIXUP,
      ST_MUL_XL,
      ST_MUL_XH,
      ST_MUL_ZL,
      ST_MUL_ZH,
      ST_ROUND,
      ST_WRITE
   } ddo_state_type;

   typedef struct packed {
      logic capture;   // take the input item
      logic setup;     // travel, heading step, rotator start
      logic rotate;    // one rotator iteration
      logic fixup;     // quadrant map, clamp, magnitudes
      logic mul_en;    // one partial product
      logic mul_hi;    // high slice of the travel magnitude
      logic mul_z;     // cosine product (else sine)
      logic round;     // round and sign the position steps
      logic write;     // commit pose and load the result register
   } ddo_cmd_type;

   typedef struct packed {
      logic iter_last;
      logic out_free;
   } ddo_status_type;

endpackage

`default_nettype wire

// ----- rtl/ddo_ctrl.sv -----
// Sequencer for the odometry datapath: one item from capture to result.
`timescale 1ns / 1ps
`default_nettype none

module ddo_ctrl
   import ddo_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire ddo_status_type status,
   output ddo_cmd_type         cmd
);

   ddo_state_type state_ff;
   ddo_state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SETUP;
         end
         ST_SETUP:  state_in = ST_ROTATE;
         ST_ROTATE: begin
            if (status.iter_last) state_in = ST_FIXUP;
         end
         ST_FIXUP:  state_in = ST_MUL_XL;
         ST_MUL_XL: state_in = ST_MUL_XH;
         ST_MUL_XH: state_in = ST_MUL_ZL;
         ST_MUL_ZL: state_in = ST_MUL_ZH;
         ST_MUL_ZH: state_in = ST_ROUND;
         ST_ROUND:  state_in = ST_WRITE;
         ST_WRITE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Commands per state
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_SETUP:  cmd.setup  = 1'b1;
         ST_ROTATE: cmd.rotate = 1'b1;
         ST_FIXUP:  cmd.fixup  = 1'b1;
         ST_MUL_XL: cmd.mul_en = 1'b1;
         ST_MUL_XH: begin
            cmd.mul_en = 1'b1;
            cmd.mul_hi = 1'b1;
         end
         ST_MUL_ZL: begin
            cmd.mul_en = 1'b1;
            cmd.mul_z  = 1'b1;
         end
         ST_MUL_ZH: begin
            cmd.mul_en = 1'b1;
            cmd.mul_hi = 1'b1;
            cmd.mul_z  = 1'b1;
         end
         ST_ROUND:  cmd.round = 1'b1;
         ST_WRITE:  cmd.write = status.out_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/ddo_datapath.sv -----
// Odometry datapath: CORDIC rotator, shared multiplier, rounding and pose registers.
`timescale 1ns / 1ps
`default_nettype none

module ddo_datapath
   import ddo_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEFAULT,
   parameter int POS_FRAC_BITS     = POS_FRAC_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ddo_cmd_type            cmd,
   output ddo_status_type              status,
   input  wire ddo_req_type            req_data,
   output ddo_rsp_type                 rsp_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire logic                   csr_valid,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int ITER_W = $clog2(CORDIC_ITERATIONS);
   localparam int SH     = 63 - POS_FRAC_BITS;
   localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (SH - 1);
   localparam logic signed [DELTA_W:0] SUM_MAX = (DELTA_W+1)'(POS_MAX);
   localparam logic signed [DELTA_W:0] SUM_MIN = (DELTA_W+1)'(POS_MIN);
   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;

   // Subtract a step from a position and saturate to the position range
   function automatic logic signed [POS_W-1:0] sat_sub(
      input logic signed [POS_W-1:0]   pos,
      input logic signed [DELTA_W-1:0] delta
   );
      logic signed [DELTA_W:0] diff;
      logic signed [POS_W-1:0] res;
      diff = (DELTA_W+1)'(pos) - (DELTA_W+1)'(delta);
      if (diff > SUM_MAX) begin
         res = POS_MAX;
      end else if (diff < SUM_MIN) begin
         res = POS_MIN;
      end else begin
         res = POS_W'(diff);
      end
      return res;
   endfunction

   // Registers
   ddo_req_type                  req_ff;
   logic signed [TRAVEL_W-1:0]   travel_ff,  travel_in;
   logic [ANGLE_W-1:0]           dh_ff,      dh_in;
   logic signed [CORDIC_W-1:0]   cx_ff,      cx_in;
   logic signed [CORDIC_W-1:0]   cy_ff,      cy_in;
   logic signed [ZW-1:0]         cz_ff,      cz_in;
   logic [ITER_W-1:0]            iter_ff,    iter_in;
   logic [1:0]                   quad_ff,    quad_in;
   logic [TRAVEL_W-1:0]          ma_ff,      ma_in;
   logic [MAG_W-1:0]             ms_ff,      ms_in;
   logic [MAG_W-1:0]             mc_ff,      mc_in;
   logic                         neg_x_ff,   neg_x_in;
   logic                         neg_z_ff,   neg_z_in;
   logic [PROD_W-1:0]            prod_x_ff,  prod_x_in;
   logic [PROD_W-1:0]            prod_z_ff,  prod_z_in;
   logic signed [DELTA_W-1:0]    delta_x_ff, delta_x_in;
   logic signed [DELTA_W-1:0]    delta_z_ff, delta_z_in;
   logic signed [POS_W-1:0]      pos_x_ff,   pos_x_in;
   logic signed [POS_W-1:0]      pos_z_ff,   pos_z_in;
   logic [ANGLE_W-1:0]           heading_ff, heading_in;
   logic [DPS_W-1:0]             dps_ff,     dps_in;
   logic [APS_W-1:0]             aps_ff,     aps_in;
   ddo_rsp_type                  rsp_data_ff, rsp_data_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // Combinational terms
   logic signed [SUM_W-1:0]      step_sum;
   logic signed [SUM_W-1:0]      step_diff;
   logic signed [TRAVEL_W:0]     travel_full;
   logic signed [SUM_W+APS_W:0]  dh_full;
   logic signed [CORDIC_W-1:0]   cx_shift;
   logic signed [CORDIC_W-1:0]   cy_shift;
   logic signed [ZW-1:0]         atan_s;
   logic signed [CORDIC_W-1:0]   sin_raw,  cos_raw;
   logic signed [CORDIC_W-1:0]   sin_cl,   cos_cl;
   logic [SPLIT_W-1:0]           mul_a;
   logic [MAG_W-1:0]             mul_b;
   logic [SPLIT_W+MAG_W-1:0]     pp;
   logic [PROD_W-1:0]            pp_ext;
   logic [PROD_W-1:0]            rnd_x,    rnd_z;
   logic [DELTA_W-1:0]           mag_x,    mag_z;
   logic signed [POS_W-1:0]      sat_x,    sat_z;

   // Travel (twice the distance) and heading step
   assign step_sum    = {req_ff.left_steps[STEP_W-1], req_ff.left_steps}
                      + {req_ff.right_steps[STEP_W-1], req_ff.right_steps};
   assign step_diff   = {req_ff.right_steps[STEP_W-1], req_ff.right_steps}
                      - {req_ff.left_steps[STEP_W-1], req_ff.left_steps};
   assign travel_full = step_sum * $signed({1'b0, dps_ff});
   assign dh_full     = step_diff * $signed({1'b0, aps_ff});

   // Rotator shift-add terms
   assign cx_shift = cx_ff >>> iter_ff;
   assign cy_shift = cy_ff >>> iter_ff;
   assign atan_s   = $signed(atan_entry(ATAN_IDX_W'(iter_ff)));

   // Map the rotator output to the heading's quadrant
   always_comb begin
      case (quad_ff)
         QUAD_FIRST: begin
            sin_raw = cy_ff;
            cos_raw = cx_ff;
         end
         QUAD_SECOND: begin
            sin_raw = cx_ff;
            cos_raw = -cy_ff;
         end
         QUAD_THIRD: begin
            sin_raw = -cy_ff;
            cos_raw = -cx_ff;
         end
         default: begin
            sin_raw = -cx_ff;
            cos_raw = cy_ff;
         end
      endcase
   end

   // Clamp sine and cosine to plus or minus one
   assign sin_cl = (sin_raw > Q30_ONE) ? Q30_ONE : ((sin_raw < Q30_NEG) ? Q30_NEG : sin_raw);
   assign cos_cl = (cos_raw > Q30_ONE) ? Q30_ONE : ((cos_raw < Q30_NEG) ? Q30_NEG : cos_raw);

   // Shared multiplier: one slice of the travel magnitude by sine or cosine
   assign mul_a  = cmd.mul_hi ? SPLIT_W'(ma_ff[TRAVEL_W-1:SPLIT_W]) : ma_ff[SPLIT_W-1:0];
   assign mul_b  = cmd.mul_z ? mc_ff : ms_ff;
   assign pp     = mul_a * mul_b;
   assign pp_ext = PROD_W'(pp);

   // Round to nearest on the magnitude, ties away from zero
   assign rnd_x = prod_x_ff + ROUND_BIAS;
   assign rnd_z = prod_z_ff + ROUND_BIAS;
   assign mag_x = DELTA_W'(rnd_x >> SH);
   assign mag_z = DELTA_W'(rnd_z >> SH);

   // Saturated new position
   assign sat_x = sat_sub(pos_x_ff, delta_x_ff);
   assign sat_z = sat_sub(pos_z_ff, delta_z_ff);

   // Next values
   always_comb begin
      travel_in    = travel_ff;
      dh_in        = dh_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      iter_in      = iter_ff;
      quad_in      = quad_ff;
      ma_in        = ma_ff;
      ms_in        = ms_ff;
      mc_in        = mc_ff;
      neg_x_in     = neg_x_ff;
      neg_z_in     = neg_z_ff;
      prod_x_in    = prod_x_ff;
      prod_z_in    = prod_z_ff;
      delta_x_in   = delta_x_ff;
      delta_z_in   = delta_z_ff;
      pos_x_in     = pos_x_ff;
      pos_z_in     = pos_z_ff;
      heading_in   = heading_ff;
      dps_in       = dps_ff;
      aps_in       = aps_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;

      // Start the rotator on the old heading
      if (cmd.setup) begin
         travel_in = travel_full[TRAVEL_W-1:0];
         dh_in     = dh_full[ANGLE_W-1:0];
         cx_in     = CORDIC_GAIN;
         cy_in     = '0;
         cz_in     = $signed({2'b00, heading_ff[ANGLE_W-3:0]});
         quad_in   = heading_ff[ANGLE_W-1:ANGLE_W-2];
         iter_in   = '0;
      end

      // Advance one rotation toward zero residual angle
      if (cmd.rotate) begin
         if (!cz_ff[ZW-1]) begin
            cx_in = cx_ff - cy_shift;
            cy_in = cy_ff + cx_shift;
            cz_in = cz_ff - atan_s;
         end else begin
            cx_in = cx_ff + cy_shift;
            cy_in = cy_ff - cx_shift;
            cz_in = cz_ff + atan_s;
         end
         iter_in = iter_ff + ITER_W'(1);
      end

      // Split into magnitudes and result signs
      if (cmd.fixup) begin
         ma_in    = travel_ff[TRAVEL_W-1] ? TRAVEL_W'(-travel_ff) : TRAVEL_W'(travel_ff);
         ms_in    = MAG_W'(sin_cl[CORDIC_W-1] ? -sin_cl : sin_cl);
         mc_in    = MAG_W'(cos_cl[CORDIC_W-1] ? -cos_cl : cos_cl);
         neg_x_in = travel_ff[TRAVEL_W-1] ^ sin_cl[CORDIC_W-1];
         neg_z_in = travel_ff[TRAVEL_W-1] ^ cos_cl[CORDIC_W-1];
      end

      // Accumulate partial products
      if (cmd.mul_en) begin
         if (cmd.mul_z) begin
            prod_z_in = cmd.mul_hi ? (prod_z_ff + (pp_ext << SPLIT_W)) : pp_ext;
         end else begin
            prod_x_in = cmd.mul_hi ? (prod_x_ff + (pp_ext << SPLIT_W)) : pp_ext;
         end
      end

      // Apply the signs to the rounded steps
      if (cmd.round) begin
         delta_x_in = neg_x_ff ? -$signed(mag_x) : $signed(mag_x);
         delta_z_in = neg_z_ff ? -$signed(mag_z) : $signed(mag_z);
      end

      // Drop the result once taken
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Commit pose and present the result item
      if (cmd.write) begin
         pos_x_in                  = sat_x;
         pos_z_in                  = sat_z;
         heading_in                = heading_ff + dh_ff;
         rsp_data_in.x_position    = sat_x;
         rsp_data_in.z_position    = sat_z;
         rsp_data_in.heading_angle = heading_ff + dh_ff;
         rsp_valid_in              = 1'b1;
      end

      // Configuration writes; other indexes are ignored
      if (csr_valid && (csr_index == CSR_DISTANCE_PER_STEP)) begin
         dps_in = csr_data[DPS_W-1:0];
      end
      if (csr_valid && (csr_index == CSR_ANGLE_PER_STEP)) begin
         aps_in = csr_data[APS_W-1:0];
      end
   end

   // Control and pose state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= '0;
         pos_z_ff     <= '0;
         heading_ff   <= '0;
         dps_ff       <= DPS_RESET;
         aps_ff       <= APS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_x_ff     <= pos_x_in;
         pos_z_ff     <= pos_z_in;
         heading_ff   <= heading_in;
         dps_ff       <= dps_in;
         aps_ff       <= aps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      travel_ff   <= travel_in;
      dh_ff       <= dh_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      iter_ff     <= iter_in;
      quad_ff     <= quad_in;
      ma_ff       <= ma_in;
      ms_ff       <= ms_in;
      mc_ff       <= mc_in;
      neg_x_ff    <= neg_x_in;
      neg_z_ff    <= neg_z_in;
      prod_x_ff   <= prod_x_in;
      prod_z_ff   <= prod_z_in;
      delta_x_ff  <= delta_x_in;
      delta_z_ff  <= delta_z_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.iter_last = (iter_ff == ITER_W'(CORDIC_ITERATIONS - 1));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_data         = rsp_data_ff;
   assign rsp_valid        = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- rtl/differential_drive_odometry_unit.sv -----
// One item at a time: a new item is accepted only after the previous one is written back.
// The iterative rotator takes one shift-add step per cycle, and the 21x31 multiplier is shared
// by the low and high slices of the sine and cosine products.
// The result register frees the input side: a new item is taken while a result waits.
// Reset (synchronous): pose and heading clear to zero, step scales load their defaults.
`timescale 1ns / 1ps
`default_nettype none

module differential_drive_odometry_unit
   import ddo_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEFAULT,
   parameter int POS_FRAC_BITS     = POS_FRAC_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire ddo_req_type            req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output ddo_rsp_type                 rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   ddo_cmd_type    cmd;
   ddo_status_type status;

   // Registers take a write in any cycle
   assign csr_ready = 1'b1;

   ddo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ddo_datapath #(
      .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
      .POS_FRAC_BITS     (POS_FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

`ifndef SYNTH
   // One item in flight: the input closes right after an accept
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input still open after item accept");

   // A result appears only at the end of an item's work
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready && cmd.write))
      else $error("result raised outside write-back");

   // Datapath phases never overlap
   a_phase_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.setup, cmd.rotate, cmd.fixup, cmd.mul_en,
                cmd.round, cmd.write}))
      else $error("overlapping datapath commands");
`endif

endmodule

`default_nettype wire
